// ===== rtl/sfe_pkg.sv =====
// Shared constants and types for the framebuffer span fill engine.
package sfe_pkg;

  // Screen size defaults, handed to the top level parameters.
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_ROWS    = 128;

  // Fixed field widths.
  localparam int COORD_W = 8;
  localparam int LEN_W   = 9;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 17;
  localparam int MODE_W  = 3;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_PLOT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HRUN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VRUN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ = 3'd4;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_SETUP   = 7'b0000100,
    ST_FILL    = 7'b0001000,
    ST_RD_ADDR = 7'b0010000,
    ST_RD_DATA = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

endpackage

// ===== rtl/sfe_frame_mem.sv =====
// Frame store: one write port and one read port with registered read data.
module sfe_frame_mem
  import sfe_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [COLOR_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/framebuffer_span_fill_engine.sv =====
// Flow: an accepted item passes through setup, then writes its span of N pixels, N being
// the count after clipping (one store write per cycle), or for a read presents the address
// and captures the data; its result then waits for the output register. No new item is
// accepted before the last one has reached the output register.
// Reset: synchronous, active low. After reset the store is cleared to black, one pixel a
// cycle, during which no item is accepted; the result register is empty after reset.
module framebuffer_span_fill_engine
  import sfe_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [COORD_W-1:0] in_x_start,
  input  logic [COORD_W-1:0] in_y_start,
  input  logic [COORD_W-1:0] in_span_width,
  input  logic [COORD_W-1:0] in_span_height,
  input  logic [COLOR_W-1:0] in_fill_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_read_color,
  output logic [COUNT_W-1:0] out_pixels_written
);

  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;

  // Command registers.
  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] x_r, y_r, w_r, h_r;
  logic [COLOR_W-1:0] color_r;

  // Span walker registers.
  logic [AW-1:0]    clr_addr_r;
  logic [AW-1:0]    addr_r, row_addr_r;
  logic [LEN_W-1:0] cw_r, col_left_r, row_left_r;

  // Result and output registers.
  logic [COLOR_W-1:0] res_color_r;
  logic [COUNT_W-1:0] res_count_r;
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [COUNT_W-1:0] out_count_r;

  // Store port signals.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic [COLOR_W-1:0] mem_rdata;

  // Setup stage decode.
  logic               on_screen, is_write, is_read;
  logic [LEN_W-1:0]   avail_x, avail_y, w_ext, h_ext, w_clip_x, w_clip_y, h_clip_y;
  logic [LEN_W-1:0]   cw, ch;
  logic [COUNT_W-1:0] base_full;
  logic [COUNT_W-1:0] count;

  logic in_accept, out_free;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Clipping of lengths against the right and bottom edges.
  always_comb begin
    on_screen = ({1'b0, x_r} < LEN_W'(SCREEN_COLUMNS))
             && ({1'b0, y_r} < LEN_W'(SCREEN_ROWS));
    avail_x   = LEN_W'(SCREEN_COLUMNS) - {1'b0, x_r};
    avail_y   = LEN_W'(SCREEN_ROWS) - {1'b0, y_r};
    w_ext     = {1'b0, w_r};
    h_ext     = {1'b0, h_r};
    w_clip_x  = (w_ext > avail_x) ? avail_x : w_ext;
    w_clip_y  = (w_ext > avail_y) ? avail_y : w_ext;
    h_clip_y  = (h_ext > avail_y) ? avail_y : h_ext;
    is_write  = 1'b0;
    is_read   = 1'b0;
    cw        = '0;
    ch        = '0;
    unique case (mode_r)
      MODE_PLOT: begin
        is_write = on_screen;
        cw       = LEN_W'(1);
        ch       = LEN_W'(1);
      end
      MODE_HRUN: begin
        is_write = on_screen;
        cw       = w_clip_x;
        ch       = LEN_W'(1);
      end
      MODE_VRUN: begin
        is_write = on_screen;
        cw       = LEN_W'(1);
        ch       = w_clip_y;
      end
      MODE_RECT: begin
        is_write = on_screen;
        cw       = w_clip_x;
        ch       = h_clip_y;
      end
      MODE_READ: begin
        is_read = on_screen;
      end
      default: begin
        is_write = 1'b0;
      end
    endcase
    count     = is_write ? (COUNT_W'(cw) * COUNT_W'(ch)) : '0;
    base_full = COUNT_W'(x_r) + COUNT_W'(SCREEN_COLUMNS) * COUNT_W'(y_r);
  end

  // Sequencer: only one command is in flight, so a read never overlaps a write.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        priority if (is_write && (count != '0)) begin
          state_nxt = ST_FILL;
        end else if (is_read) begin
          state_nxt = ST_RD_ADDR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        if ((col_left_r == LEN_W'(1)) && (row_left_r == LEN_W'(1))) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command capture, span walking and result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r  <= in_mode;
      x_r     <= in_x_start;
      y_r     <= in_y_start;
      w_r     <= in_span_width;
      h_r     <= in_span_height;
      color_r <= in_fill_color;
    end
    if (state_r == ST_SETUP) begin
      addr_r      <= AW'(base_full);
      row_addr_r  <= AW'(base_full);
      cw_r        <= cw;
      col_left_r  <= cw;
      row_left_r  <= ch;
      res_color_r <= '0;
      res_count_r <= count;
    end
    if (state_r == ST_FILL) begin
      if (col_left_r == LEN_W'(1)) begin
        // Step to the start of the next row.
        row_addr_r <= row_addr_r + AW'(SCREEN_COLUMNS);
        addr_r     <= row_addr_r + AW'(SCREEN_COLUMNS);
        col_left_r <= cw_r;
        row_left_r <= row_left_r - LEN_W'(1);
      end else begin
        addr_r     <= addr_r + AW'(1);
        col_left_r <= col_left_r - LEN_W'(1);
      end
    end
    if (state_r == ST_RD_DATA) begin
      res_color_r <= mem_rdata;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_color_r <= res_color_r;
      out_count_r <= res_count_r;
    end
  end

  // Store port: clearing pass or span writes.
  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_FILL);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : color_r;

  sfe_frame_mem #(
    .DEPTH(DEPTH)
  ) u_frame_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(row_addr_r),
    .rd_data(mem_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_read_color     = out_color_r;
  assign out_pixels_written = out_count_r;

endmodule

// ===== rtl/sfe_checker.sv =====
// Port-level checks on the span fill engine, bound to its top level.
module sfe_checker
  import sfe_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COLOR_W-1:0] out_read_color,
  input logic [COUNT_W-1:0] out_pixels_written
);

  // The store is cleared after reset, so no item may be taken straight away.
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("item accepted directly after reset");

  // The engine works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while engine busy");

  // A result either reads back a colour or reports writes, never both.
  a_read_or_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_read_color == '0) || (out_pixels_written == '0)))
    else $error("result carries both a colour and a pixel count");

  // A stalled result stays presented.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind framebuffer_span_fill_engine sfe_checker u_sfe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_read_color    (out_read_color),
  .out_pixels_written(out_pixels_written)
);
